FILE: src/rbsi_pkg.sv
// ----------------------------------------------------------------------------
// rbsi_pkg: shared types and constants for the ray/box slab intersector
// widths of the divider pipeline, slab distance format and saturation helper
// ----------------------------------------------------------------------------
package rbsi_pkg;

    // magnitude widths of the divider: numerator (bound - origin) << 16, divisor
    localparam int NW = 48;
    localparam int RW = 32;
    // signed slab distance width, wide enough for the +/- infinity marks
    localparam int TW = 51;
    // capture stage, one stage per quotient bit, sign stage
    localparam int DIV_LAT = NW + 2;
    // divider, lane min/max stage, two merge stages
    localparam int LAT = DIV_LAT + 3;

    localparam logic signed [TW-1:0] T_INF     = TW'(64'sd1 <<< 49);
    localparam logic signed [TW-1:0] T_NEG_INF = -T_INF;
    localparam logic signed [TW-1:0] T_MAX32   = TW'(64'sd2147483647);
    localparam logic signed [TW-1:0] T_MIN32   = TW'(-64'sd2147483648);

    typedef struct packed {
        logic signed [TW-1:0] entry;
        logic signed [TW-1:0] leave;
    } slab_t;

    function automatic logic signed [31:0] sat32(input logic signed [TW-1:0] x);
        logic signed [31:0] r;
        if (x > T_MAX32)
            r = 32'sh7fffffff;
        else if (x < T_MIN32)
            r = 32'sh80000000;
        else
            r = x[31:0];
        return r;
    endfunction

endpackage

FILE: src/rbsi_divider.sv
// ----------------------------------------------------------------------------
// rbsi_divider: pipelined signed divider
// restoring division, one quotient bit per stage, truncates toward zero
// ----------------------------------------------------------------------------
module rbsi_divider
(
    input  logic                             clk,
    input  logic                             en,
    input  logic signed [rbsi_pkg::NW:0]     num,
    input  logic signed [rbsi_pkg::RW-1:0]   den,
    output logic signed [rbsi_pkg::TW-1:0]   quo
);
    localparam int NW = rbsi_pkg::NW;
    localparam int RW = rbsi_pkg::RW;
    localparam int TW = rbsi_pkg::TW;

    logic [RW-1:0] r_reg [0:NW];
    logic [NW-1:0] n_reg [0:NW];
    logic [NW-1:0] q_reg [0:NW];
    logic [RW-1:0] d_reg [0:NW];
    logic          neg_reg [0:NW];
    logic signed [TW-1:0] quo_reg;

    logic [NW:0]   num_mag;
    logic [RW-1:0] den_mag;

    // magnitudes and sign of the quotient
    assign num_mag = num[NW] ? (NW+1)'(-num) : num;
    assign den_mag = den[RW-1] ? RW'(-den) : den;

    // capture stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0]   <= '0;
            n_reg[0]   <= num_mag[NW-1:0];
            q_reg[0]   <= '0;
            d_reg[0]   <= den_mag;
            neg_reg[0] <= num[NW] ^ den[RW-1];
        end
    end

    // one quotient bit per stage
    for (genvar i = 1; i <= NW; i++)
    begin : g_step
        logic [RW:0] trial;
        logic        fits;
        assign trial = {r_reg[i-1], n_reg[i-1][NW-1]};
        assign fits  = trial >= {1'b0, d_reg[i-1]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[i]   <= fits ? RW'(trial - {1'b0, d_reg[i-1]}) : trial[RW-1:0];
                n_reg[i]   <= {n_reg[i-1][NW-2:0], 1'b0};
                q_reg[i]   <= {q_reg[i-1][NW-2:0], fits};
                d_reg[i]   <= d_reg[i-1];
                neg_reg[i] <= neg_reg[i-1];
            end
        end
    end

    // restore the sign
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg <= neg_reg[NW] ? -TW'({1'b0, q_reg[NW]}) : TW'({1'b0, q_reg[NW]});
        end
    end

    assign quo = quo_reg;

endmodule

FILE: src/rbsi_lane.sv
// ----------------------------------------------------------------------------
// rbsi_lane: one axis of the slab test
// two slab distances through dividers, then ordered into entry and exit
// ----------------------------------------------------------------------------
module rbsi_lane
(
    input  logic                  clk,
    input  logic                  en,
    input  logic signed [31:0]    lo,
    input  logic signed [31:0]    hi,
    input  logic signed [31:0]    org,
    input  logic signed [31:0]    dir,
    output rbsi_pkg::slab_t       slab
);
    localparam int NW  = rbsi_pkg::NW;
    localparam int TW  = rbsi_pkg::TW;
    localparam int DL  = rbsi_pkg::DIV_LAT;

    logic signed [32:0] diff_lo, diff_hi;
    logic signed [NW:0] num_lo, num_hi;
    logic signed [TW-1:0] q_lo, q_hi;
    logic zero_reg [0:DL-1];
    logic inside_reg [0:DL-1];
    rbsi_pkg::slab_t slab_reg;

    // exact differences scaled by 2^16
    assign diff_lo = 33'(lo) - 33'(org);
    assign diff_hi = 33'(hi) - 33'(org);
    assign num_lo  = {diff_lo[32:0], 16'd0};
    assign num_hi  = {diff_hi[32:0], 16'd0};

    rbsi_divider u_div_lo (.clk(clk), .en(en), .num(num_lo), .den(dir), .quo(q_lo));
    rbsi_divider u_div_hi (.clk(clk), .en(en), .num(num_hi), .den(dir), .quo(q_hi));

    // zero direction flags follow the divider
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg[0]   <= dir == 32'sd0;
            inside_reg[0] <= (org >= lo) && (org <= hi);
            for (int i = 1; i < DL; i++)
            begin
                zero_reg[i]   <= zero_reg[i-1];
                inside_reg[i] <= inside_reg[i-1];
            end
        end
    end

    // order the two distances, zero direction gives open or empty slab
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (zero_reg[DL-1])
            begin
                slab_reg.entry <= inside_reg[DL-1] ? rbsi_pkg::T_NEG_INF : rbsi_pkg::T_INF;
                slab_reg.leave <= inside_reg[DL-1] ? rbsi_pkg::T_INF : rbsi_pkg::T_NEG_INF;
            end
            else
            begin
                slab_reg.entry <= (q_lo < q_hi) ? q_lo : q_hi;
                slab_reg.leave <= (q_lo < q_hi) ? q_hi : q_lo;
            end
        end
    end

    assign slab = slab_reg;

endmodule

FILE: src/rbsi_merge.sv
// ----------------------------------------------------------------------------
// rbsi_merge: combines the three axis results
// near is the largest entry, far the smallest exit, then hit and saturation
// ----------------------------------------------------------------------------
module rbsi_merge
(
    input  logic                clk,
    input  logic                en,
    input  rbsi_pkg::slab_t     sx,
    input  rbsi_pkg::slab_t     sy,
    input  rbsi_pkg::slab_t     sz,
    output logic                hit,
    output logic signed [31:0]  entry_distance,
    output logic signed [31:0]  t_near,
    output logic signed [31:0]  t_far
);
    localparam int TW = rbsi_pkg::TW;

    logic signed [TW-1:0] tn_reg, tf_reg;
    logic signed [TW-1:0] tn_xy, tf_xy, tn_next, tf_next;
    logic hit_reg, hit_next;
    logic signed [31:0] ed_reg, tn32_reg, tf32_reg;

    // max of entries, min of exits
    always_comb
    begin
        tn_xy   = (sy.entry > sx.entry) ? sy.entry : sx.entry;
        tf_xy   = (sy.leave < sx.leave) ? sy.leave : sx.leave;
        tn_next = (sz.entry > tn_xy) ? sz.entry : tn_xy;
        tf_next = (sz.leave < tf_xy) ? sz.leave : tf_xy;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tn_reg <= tn_next;
            tf_reg <= tf_next;
        end
    end

    // hit decision on exact distances
    assign hit_next = !(tf_reg < 0 || tn_reg > tf_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg  <= hit_next;
            ed_reg   <= rbsi_pkg::sat32(hit_next ? tn_reg : tf_reg);
            tn32_reg <= rbsi_pkg::sat32(tn_reg);
            tf32_reg <= rbsi_pkg::sat32(tf_reg);
        end
    end

    assign hit            = hit_reg;
    assign entry_distance = ed_reg;
    assign t_near         = tn32_reg;
    assign t_far          = tf32_reg;

endmodule

FILE: src/ray_box_slab_intersect.sv
// ----------------------------------------------------------------------------
// ray_box_slab_intersect: ray against axis-aligned box, Q16.16 slab method
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall   box, origin, direction
//   out      output     out_valid / out_stall hit, distances
//
// one transaction per cycle while no result is stalled; depth set by the divider pipeline
// (one quotient bit per stage) plus ordering and merge stages.
// reset clears only the valid pipeline; no clearing pass.
// a stalled result freezes the whole pipeline and raises in_stall.
// ----------------------------------------------------------------------------
module ray_box_slab_intersect
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [31:0]  box_min_x,
    input  logic signed [31:0]  box_min_y,
    input  logic signed [31:0]  box_min_z,
    input  logic signed [31:0]  box_max_x,
    input  logic signed [31:0]  box_max_y,
    input  logic signed [31:0]  box_max_z,
    input  logic signed [31:0]  origin_x,
    input  logic signed [31:0]  origin_y,
    input  logic signed [31:0]  origin_z,
    input  logic signed [31:0]  dir_x,
    input  logic signed [31:0]  dir_y,
    input  logic signed [31:0]  dir_z,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                hit,
    output logic signed [31:0]  entry_distance,
    output logic signed [31:0]  t_near,
    output logic signed [31:0]  t_far
);
    localparam int LAT = rbsi_pkg::LAT;

    logic [LAT-1:0] vld_reg, vld_next;
    logic en;
    rbsi_pkg::slab_t sx, sy, sz;

    // pipeline advances unless a finished result is held
    assign en       = !(vld_reg[LAT-1] && out_stall);
    assign in_stall = !en;

    assign vld_next = {vld_reg[LAT-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    assign out_valid = vld_reg[LAT-1];

    // one lane per axis
    rbsi_lane u_lane_x (.clk(clk), .en(en), .lo(box_min_x), .hi(box_max_x),
                        .org(origin_x), .dir(dir_x), .slab(sx));
    rbsi_lane u_lane_y (.clk(clk), .en(en), .lo(box_min_y), .hi(box_max_y),
                        .org(origin_y), .dir(dir_y), .slab(sy));
    rbsi_lane u_lane_z (.clk(clk), .en(en), .lo(box_min_z), .hi(box_max_z),
                        .org(origin_z), .dir(dir_z), .slab(sz));

    rbsi_merge u_merge (.clk(clk), .en(en), .sx(sx), .sy(sy), .sz(sz), .hit(hit),
                        .entry_distance(entry_distance), .t_near(t_near), .t_far(t_far));

    // checks
    a_hold_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("input taken while result stalled");

    a_hit_distance: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> entry_distance == t_near && t_near <= t_far)
        else $error("hit result inconsistent");

    a_accept_tracked: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> vld_reg[0])
        else $error("accepted transaction lost");

endmodule

FILE: tb/rbsi_checker.sv
// ----------------------------------------------------------------------------
// rbsi_checker: result checker for the ray/box slab intersector
// watches both channels, computes the expected hit and distances for every
// accepted ray/box transaction and compares each accepted result in order
// ----------------------------------------------------------------------------
module rbsi_checker
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic signed [31:0]  box_min_x,
    input  logic signed [31:0]  box_min_y,
    input  logic signed [31:0]  box_min_z,
    input  logic signed [31:0]  box_max_x,
    input  logic signed [31:0]  box_max_y,
    input  logic signed [31:0]  box_max_z,
    input  logic signed [31:0]  origin_x,
    input  logic signed [31:0]  origin_y,
    input  logic signed [31:0]  origin_z,
    input  logic signed [31:0]  dir_x,
    input  logic signed [31:0]  dir_y,
    input  logic signed [31:0]  dir_z,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic                hit,
    input  logic signed [31:0]  entry_distance,
    input  logic signed [31:0]  t_near,
    input  logic signed [31:0]  t_far,
    output int                  fail_count,
    output int                  pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic               hit;
        logic signed [31:0] distance;
        logic signed [31:0] near;
        logic signed [31:0] far;
    } hit_result_t;

    localparam longint UNBOUNDED = 64'sd1 <<< 60;

    // expected results in arrival order, written at wr_idx, read at rd_idx
    hit_result_t expected_hits[int];
    int          wr_idx;
    int          rd_idx;

    function automatic logic signed [31:0] clamp32(longint x);
        if (x > 64'sd2147483647)
            return 32'sh7fffffff;
        if (x < -64'sd2147483648)
            return 32'sh80000000;
        return x[31:0];
    endfunction

    // exact slab entry/exit on one axis, zero direction repaired
    function automatic void axis_span(longint lo, longint hi, longint org, longint d,
                                      output longint enter, output longint leave);
        longint a, b;
        if (d == 0)
        begin
            if (org >= lo && org <= hi)
            begin
                enter = -UNBOUNDED;
                leave = UNBOUNDED;
            end
            else
            begin
                enter = UNBOUNDED;
                leave = -UNBOUNDED;
            end
            return;
        end
        a = ((lo - org) * 65536) / d;
        b = ((hi - org) * 65536) / d;
        enter = (a < b) ? a : b;
        leave = (a < b) ? b : a;
    endfunction

    function automatic hit_result_t predict_hit();
        longint lo[3], hi[3], org[3], d[3];
        longint e, l, tn, tf;
        hit_result_t r;
        lo  = '{box_min_x, box_min_y, box_min_z};
        hi  = '{box_max_x, box_max_y, box_max_z};
        org = '{origin_x, origin_y, origin_z};
        d   = '{dir_x, dir_y, dir_z};
        tn = 0;
        tf = 0;
        for (int k = 0; k < 3; k++)
        begin
            axis_span(lo[k], hi[k], org[k], d[k], e, l);
            if (k == 0 || e > tn)
                tn = e;
            if (k == 0 || l < tf)
                tf = l;
        end
        r.hit      = !(tf < 0 || tn > tf);
        r.distance = clamp32(r.hit ? tn : tf);
        r.near     = clamp32(tn);
        r.far      = clamp32(tf);
        return r;
    endfunction

    assign pending_count = wr_idx - rd_idx;

    // predict on input transactions, compare on output transactions
    always @(posedge clk)
    begin
        hit_result_t exp_r;
        if (rst_n && in_valid && !in_stall)
        begin
            expected_hits[wr_idx] = predict_hit();
            wr_idx++;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (rd_idx == wr_idx)
            begin
                $error("unexpected result transaction");
                fail_count++;
            end
            else
            begin
                exp_r = expected_hits[rd_idx];
                expected_hits.delete(rd_idx);
                rd_idx++;
                if (hit !== exp_r.hit)
                begin
                    $error("hit: expected %0d actual %0d", exp_r.hit, hit);
                    fail_count++;
                end
                if (entry_distance !== exp_r.distance)
                begin
                    $error("entry_distance: expected %0d actual %0d",
                           exp_r.distance, entry_distance);
                    fail_count++;
                end
                if (t_near !== exp_r.near)
                begin
                    $error("t_near: expected %0d actual %0d", exp_r.near, t_near);
                    fail_count++;
                end
                if (t_far !== exp_r.far)
                begin
                    $error("t_far: expected %0d actual %0d", exp_r.far, t_far);
                    fail_count++;
                end
            end
        end
    end

endmodule

FILE: tb/tb_ray_box_slab_intersect.sv
// ----------------------------------------------------------------------------
// tb_ray_box_slab_intersect: testbench for the ray/box slab intersector
// directed corner rays then random box/ray transactions over four idle/stall
// phases; the checker predicts and compares, this module drives and judges
// ----------------------------------------------------------------------------
module tb_ray_box_slab_intersect;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY     = 53;
    localparam int STALL_LIMIT = 5000;
    localparam int N_RANDOM    = 1150;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] box_min_x, box_min_y, box_min_z;
    logic signed [31:0] box_max_x, box_max_y, box_max_z;
    logic signed [31:0] origin_x, origin_y, origin_z;
    logic signed [31:0] dir_x, dir_y, dir_z;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               hit;
    logic signed [31:0] entry_distance, t_near, t_far;
    int                 fail_count;
    int                 pending_count;
    int                 send_idle_pct;
    int                 recv_stall_pct;
    int                 quiet_cycles;

    ray_box_slab_intersect u_top (.*);

    rbsi_checker u_checker (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // random receiver stall
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    // watchdog: cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // random coordinate biased toward corners, zero and small values
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(9))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 0;
            3: return $urandom();
            4, 5: return $signed($urandom_range(2 * 65536 * 64)) - 65536 * 64;
            default: return $signed($urandom_range(2 * 65536 * 1024)) - 65536 * 1024;
        endcase
    endfunction

    function automatic logic signed [31:0] pick_dir();
        case ($urandom_range(9))
            0, 1: return 0;
            2: return $urandom();
            3: return $signed($urandom_range(64)) - 32;
            default: return $signed($urandom_range(4 * 65536)) - 2 * 65536;
        endcase
    endfunction

    // send one transaction, holding it until accepted
    task automatic send_ray(logic signed [31:0] v[12]);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        box_min_x <= v[0];  box_min_y <= v[1];  box_min_z <= v[2];
        box_max_x <= v[3];  box_max_y <= v[4];  box_max_z <= v[5];
        origin_x  <= v[6];  origin_y  <= v[7];  origin_z  <= v[8];
        dir_x     <= v[9];  dir_y     <= v[10]; dir_z     <= v[11];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    initial
    begin
        logic signed [31:0] v[12];
        int base;
        rst_n = 0;
        in_valid = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        {box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z} = '0;
        {origin_x, origin_y, origin_z, dir_x, dir_y, dir_z} = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: unit box hits, zero directions in and out of slab,
        // inverted box, behind origin, field extremes
        v = '{0, 0, 0, 65536, 65536, 65536, -65536, 32768, 32768, 65536, 0, 0};
        send_ray(v);
        v = '{0, 0, 0, 65536, 65536, 65536, -65536, 32768 * 5, 32768, 65536, 0, 0};
        send_ray(v);
        v = '{0, 0, 0, 65536, 65536, 65536, 32768, 32768, 32768, 0, 0, 0};
        send_ray(v);
        v = '{0, 0, 0, 65536, 65536, 65536, 32768, 32768, 32768, 0, 0, 65536};
        send_ray(v);
        v = '{65536, 0, 0, 0, 65536, 65536, -65536, 32768, 32768, 65536, 0, 0};
        send_ray(v);
        v = '{65536, 0, 0, 0, 65536, 65536, 32768, 32768, 32768, 0, 65536, 0};
        send_ray(v);
        v = '{0, 0, 0, 65536, 65536, 65536, 196608, 32768, 32768, 65536, 0, 0};
        send_ray(v);
        v = '{0, 0, 0, 65536, 65536, 65536, 196608, 32768, 32768, -65536, 0, 0};
        send_ray(v);
        v = '{32'sh80000000, 32'sh80000000, 32'sh80000000,
              32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
              32'sh7fffffff, 32'sh80000000, 0, 1, -1, 32'sh7fffffff};
        send_ray(v);
        v = '{32'sh80000000, 32'sh80000000, 32'sh80000000,
              32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
              32'sh80000000, 32'sh7fffffff, 0, 32'sh80000000, 32'sh80000000, -1};
        send_ray(v);
        v = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
              32'sh80000000, 32'sh80000000, 32'sh80000000,
              0, 0, 0, 1, 1, 1};
        send_ray(v);
        v = '{-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1};
        send_ray(v);
        v = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
        send_ray(v);

        // random phases: none, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = (ph == 1) ? 54 : (ph == 3) ? 18 : 0;
            recv_stall_pct = (ph == 2) ? 54 : (ph == 3) ? 18 : 0;
            for (int n = 0; n < N_RANDOM / 4; n++)
            begin
                for (int k = 0; k < 12; k++)
                    v[k] = pick_value();
                if ($urandom_range(3) != 0)
                begin
                    // mostly well-formed boxes near the ray
                    for (int k = 0; k < 3; k++)
                    begin
                        base = $signed($urandom_range(2 * 65536 * 256)) - 65536 * 256;
                        v[k] = base;
                        v[3 + k] = base + $urandom_range(65536 * 64);
                        v[6 + k] = base + $signed($urandom_range(65536 * 256))
                                   - 65536 * 96;
                        v[9 + k] = pick_dir();
                    end
                end
                send_ray(v);
            end
        end
        in_valid <= 1'b0;

        while (pending_count != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: files.f
src/rbsi_pkg.sv
src/rbsi_divider.sv
src/rbsi_lane.sv
src/rbsi_merge.sv
src/ray_box_slab_intersect.sv
tb/rbsi_checker.sv
tb/tb_ray_box_slab_intersect.sv
